FILE: src/ctc_pkg.sv
// Shared types, constants and helpers for the contact table engine.
// Used by the interfaces, the cell, the controller and the top level; no dependencies.
`default_nettype none
package ctc_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int PHONE_W     = 37;
  localparam int HEAD_W      = 64;
  localparam int TAIL_W      = 8;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 3'd0,
    OP_FIND_NAME  = 3'd1,
    OP_FIND_PHONE = 3'd2,
    OP_DEL_NAME   = 3'd3,
    OP_DEL_PHONE  = 3'd4,
    OP_LIST       = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [PHONE_W-1:0] phone;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
  } entry_t;

  // Commands from the controller to the row of cells.
  typedef struct packed {
    entry_t                 key;
    logic                   by_name;
    logic [TABLE_DEPTH-1:0] occ;
    logic [TABLE_DEPTH-1:0] wr;
    logic [TABLE_DEPTH-1:0] sh;
    logic                   rot;
    logic [CNT_W-1:0]       count;
  } cell_cmd_t;

  // A name ends at its first zero byte; every byte from there on is cleared.
  function automatic entry_t canon_key(logic [PHONE_W-1:0] phone,
                                       logic [HEAD_W-1:0] head,
                                       logic [TAIL_W-1:0] tail);
    entry_t e;
    logic   seen;
    e.phone = phone;
    e.head  = head;
    e.tail  = tail;
    seen    = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (head[HEAD_W-1-8*b -: 8] == 8'd0) seen = 1'b1;
      if (seen) e.head[HEAD_W-1-8*b -: 8] = 8'd0;
    end
    if (seen) e.tail = '0;
    return e;
  endfunction

endpackage
`default_nettype wire

FILE: src/ctc_req_if.sv
// Request channel of the contact table engine: valid/ready plus one command beat.
// Depends on ctc_pkg for field widths.
`default_nettype none
interface ctc_req_if;
  logic                           valid;
  logic                           ready;
  logic [ctc_pkg::OP_W-1:0]       opcode;
  logic [ctc_pkg::PHONE_W-1:0]    phone_number;
  logic [ctc_pkg::HEAD_W-1:0]     name_head;
  logic [ctc_pkg::TAIL_W-1:0]     name_tail;

  modport source (output valid, opcode, phone_number, name_head, name_tail, input ready);
  modport sink   (input valid, opcode, phone_number, name_head, name_tail, output ready);
endinterface
`default_nettype wire

FILE: src/ctc_rsp_if.sv
// Result channel of the contact table engine: valid/ready plus one result beat.
// Depends on ctc_pkg for field widths.
`default_nettype none
interface ctc_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ctc_pkg::STATUS_W-1:0]    status;
  logic [ctc_pkg::IDX_W-1:0]       entry_index;
  logic [ctc_pkg::PHONE_W-1:0]     entry_phone;
  logic [ctc_pkg::HEAD_W-1:0]      entry_name_head;
  logic [ctc_pkg::TAIL_W-1:0]      entry_name_tail;
  logic [ctc_pkg::CNT_W-1:0]       entry_count;
  logic                            last_result;

  modport source (output valid, status, entry_index, entry_phone, entry_name_head,
                  entry_name_tail, entry_count, last_result, input ready);
  modport sink   (input valid, status, entry_index, entry_phone, entry_name_head,
                  entry_name_tail, entry_count, last_result, output ready);
endinterface
`default_nettype wire

FILE: src/contact_table_engine_top.sv
// Top level of the contact table engine: a row of table cells and their sequencer.
// Depends on ctc_pkg, ctc_req_if, ctc_rsp_if, ctc_cell and ctc_ctrl.
//
// Usage: commands arrive as beats on req (valid/ready) and results leave as beats
// on rsp (valid/ready); a beat moves at a clock edge with valid and ready both high.
// Each command gives one result beat, except a list of a non-empty table, which
// gives one beat per entry in table order, the final one marked by last_result.
// Opcodes 6 and 7 are taken and dropped without a result.
// Add and list of an empty table go straight to the final step, which registers the
// result; find and delete first compare in every cell, then pick the first match,
// then gather and shift. A list shows one entry per cycle while the receiver takes
// each beat, as the occupied cells rotate past cell 0. A new command is taken once
// the final result of the previous one is registered. Results sit in an output
// register. While the receiver stalls, one more command can be taken; it then holds
// in its final step with req.ready low until the register empties. Reset clears the
// entry count and the result valid flag; the cell contents are not cleared and are
// never shown unwritten.
`default_nettype none
module contact_table_engine_top (
  input  wire logic clk,
  input  wire logic rst,
  ctc_req_if.sink   req,
  ctc_rsp_if.source rsp
);
  import ctc_pkg::*;

  cell_cmd_t              cmd;
  entry_t                 entries [TABLE_DEPTH];
  entry_t                 nbs     [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hits;

  ctc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .entries (entries),
    .hits    (hits),
    .cmd     (cmd)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // The highest occupied cell wraps round to cell 0 during a list.
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nbs[i] = entries[0];
    end else begin : g_mid
      assign nbs[i] = (cmd.rot && (CNT_W'(i) + CNT_W'(1) == cmd.count)) ?
                      entries[0] : entries[i+1];
    end

    ctc_cell u_cell (
      .clk      (clk),
      .key      (cmd.key),
      .by_name  (cmd.by_name),
      .occupied (cmd.occ[i]),
      .wr       (cmd.wr[i]),
      .sh       (cmd.sh[i]),
      .nb       (nbs[i]),
      .entry    (entries[i]),
      .hit      (hits[i])
    );
  end

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.entry_count <= DEPTH_CNT))
    else $error("entry count beyond table depth");

  a_full_status : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> (rsp.entry_count == DEPTH_CNT))
    else $error("table full reported with free slots");

  a_empty_status : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.entry_count == '0 && rsp.last_result))
    else $error("empty list result on a non-empty table");

  a_busy_after_take : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && (req.opcode == OP_ADD || req.opcode == OP_LIST ||
     req.opcode == OP_FIND_NAME || req.opcode == OP_FIND_PHONE ||
     req.opcode == OP_DEL_NAME || req.opcode == OP_DEL_PHONE)) |=> !req.ready)
    else $error("command taken while previous one in progress");

endmodule
`default_nettype wire

FILE: src/ctc_cell.sv
// One table slot: holds an entry, compares it with the search key, and loads
// either the key or its neighbour's entry. Depends on ctc_pkg.
`default_nettype none
module ctc_cell (
  input  wire logic            clk,
  input  wire ctc_pkg::entry_t key,
  input  wire logic            by_name,
  input  wire logic            occupied,
  input  wire logic            wr,
  input  wire logic            sh,
  input  wire ctc_pkg::entry_t nb,
  output ctc_pkg::entry_t      entry,
  output logic                 hit
);
  import ctc_pkg::*;

  always_ff @(posedge clk) begin
    if (wr) begin
      entry <= key;
    end else if (sh) begin
      entry <= nb;
    end
  end

  always_comb begin
    if (by_name) begin
      hit = occupied && (entry.head == key.head) && (entry.tail == key.tail);
    end else begin
      hit = occupied && (entry.phone == key.phone);
    end
  end

endmodule
`default_nettype wire

FILE: src/ctc_ctrl.sv
// Sequencer of the contact table engine: takes command beats, drives the row of
// cells, picks the first match and holds the result register. Depends on ctc_pkg.
`default_nettype none
module ctc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  ctc_req_if.sink                  req,
  ctc_rsp_if.source                rsp,
  input  wire ctc_pkg::entry_t     entries [ctc_pkg::TABLE_DEPTH],
  input  wire logic [ctc_pkg::TABLE_DEPTH-1:0] hits,
  output ctc_pkg::cell_cmd_t       cmd
);
  import ctc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_SEL, S_DONE, S_LIST} state_t;

  state_t                 state;
  opcode_t                op_r;
  entry_t                 key_r;
  logic [CNT_W-1:0]       count;
  logic [TABLE_DEPTH-1:0] match_r;
  logic [TABLE_DEPTH-1:0] first_r;
  logic                   found_r;
  logic [IDX_W-1:0]       list_idx;

  logic                   rsp_valid;
  status_t                rsp_status;
  logic [IDX_W-1:0]       rsp_index;
  entry_t                 rsp_entry;
  logic [CNT_W-1:0]       rsp_count;
  logic                   rsp_last;

  logic                   slot_free;
  logic                   rsp_load;
  logic                   list_last;
  logic                   by_name;
  entry_t                 sel_entry;
  logic [IDX_W-1:0]       sel_pos;
  logic [TABLE_DEPTH-1:0] occ;

  status_t                done_status;
  logic [IDX_W-1:0]       done_index;
  entry_t                 done_entry;
  logic [CNT_W-1:0]       count_next;

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.entry_index     = rsp_index;
  assign rsp.entry_phone     = rsp_entry.phone;
  assign rsp.entry_name_head = rsp_entry.head;
  assign rsp.entry_name_tail = rsp_entry.tail;
  assign rsp.entry_count     = rsp_count;
  assign rsp.last_result     = rsp_last;

  assign slot_free = !rsp_valid || rsp.ready;
  assign rsp_load  = slot_free && (state == S_DONE || state == S_LIST);
  assign list_last = (CNT_W'(list_idx) + CNT_W'(1)) == count;
  assign by_name   = (op_r == OP_FIND_NAME) || (op_r == OP_DEL_NAME);

  // The match is one-hot after selection, so an AND-OR gather suffices.
  always_comb begin
    sel_entry = '0;
    sel_pos   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_r[i]) begin
        sel_entry = sel_entry | entries[i];
        sel_pos   = sel_pos | IDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i] = CNT_W'(i) < count;
    end
  end

  // Result of a single-beat command and the entry count after it.
  always_comb begin
    done_status = ST_OK;
    done_index  = '0;
    done_entry  = '0;
    count_next  = count;
    unique case (op_r)
      OP_ADD: begin
        if (count == DEPTH_CNT) begin
          done_status = ST_FULL;
        end else begin
          done_index = count[IDX_W-1:0];
          done_entry = key_r;
          count_next = count + CNT_W'(1);
        end
      end
      OP_FIND_NAME, OP_FIND_PHONE: begin
        if (found_r) begin
          done_index = sel_pos;
          done_entry = sel_entry;
        end else begin
          done_status = ST_NOT_FOUND;
        end
      end
      OP_DEL_NAME, OP_DEL_PHONE: begin
        if (found_r) begin
          done_index = sel_pos;
          done_entry = sel_entry;
          count_next = count - CNT_W'(1);
        end else begin
          done_status = ST_NOT_FOUND;
        end
      end
      OP_LIST: begin
        done_status = ST_EMPTY;
      end
      default: begin
        done_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.key     = key_r;
    cmd.by_name = by_name;
    cmd.occ     = occ;
    cmd.count   = count;
    if (state == S_DONE && slot_free) begin
      if (op_r == OP_ADD && count != DEPTH_CNT) begin
        cmd.wr[count[IDX_W-1:0]] = 1'b1;
      end
      // Every cell from the removed one upwards takes its upper neighbour.
      if ((op_r == OP_DEL_NAME || op_r == OP_DEL_PHONE) && found_r) begin
        cmd.sh = ~(first_r - TABLE_DEPTH'(1));
      end
    end
    if (state == S_LIST && slot_free) begin
      cmd.rot = 1'b1;
      cmd.sh  = occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r     <= opcode_t'(req.opcode);
            key_r    <= canon_key(req.phone_number, req.name_head, req.name_tail);
            list_idx <= '0;
            if (req.opcode == OP_ADD) begin
              state <= S_DONE;
            end else if (req.opcode == OP_LIST) begin
              state <= (count == '0) ? S_DONE : S_LIST;
            end else if (req.opcode == OP_FIND_NAME || req.opcode == OP_FIND_PHONE ||
                         req.opcode == OP_DEL_NAME || req.opcode == OP_DEL_PHONE) begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          match_r <= hits;
          state   <= S_SEL;
        end
        S_SEL: begin
          first_r <= match_r & (~match_r + TABLE_DEPTH'(1));
          found_r <= |match_r;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            rsp_last   <= 1'b1;
            rsp_status <= done_status;
            rsp_index  <= done_index;
            rsp_entry  <= done_entry;
            rsp_count  <= count_next;
            count      <= count_next;
            state      <= S_IDLE;
          end
        end
        S_LIST: begin
          // Cell 0 is shown each beat while the occupied cells rotate by one.
          if (slot_free) begin
            rsp_status <= ST_OK;
            rsp_index  <= list_idx;
            rsp_entry  <= entries[0];
            rsp_count  <= count;
            rsp_last   <= list_last;
            list_idx   <= list_idx + IDX_W'(1);
            if (list_last) state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: dv/contact_table_engine_top_test.sv
// Self-checking testbench for contact_table_engine_top: directed commands, then random ones.
// Each command is predicted, and every result beat is compared with the oldest prediction.
// Depends on ctc_pkg, ctc_req_if, ctc_rsp_if and the RTL under src.
`default_nettype none
module contact_table_engine_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctc_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 3'd6;
  localparam int              NAME_W   = HEAD_W + TAIL_W;
  localparam int              RAND_CMDS = 95;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [PHONE_W-1:0] phone;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
  } contact_cmd_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   index;
    logic [PHONE_W-1:0] phone;
    logic [HEAD_W-1:0]  head;
    logic [TAIL_W-1:0]  tail;
    logic [CNT_W-1:0]   count;
    logic               last;
  } contact_rsp_t;

  typedef struct {
    contact_cmd_t cmd;
    int           reps;
    bit           typed;
    contact_rsp_t want;
  } plan_row_t;

  logic clk;
  logic rst;

  ctc_req_if req ();
  ctc_rsp_if rsp ();

  contact_table_engine_top uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Shadow copy of the contact table; names are held as nine bytes, head first.
  logic [PHONE_W-1:0] book_phone [TABLE_DEPTH];
  logic [NAME_W-1:0]  book_name  [TABLE_DEPTH];
  int                 book_count;

  contact_rsp_t due_rsp [$];
  int           fault_count;
  int           beats_seen;
  int           cmds_sent;
  int           full_hits;
  int           idle_pct;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("contact_table_engine_top_test: done, errors");
    $finish;
  end

  // A name stops at its first zero byte; everything after it is cleared.
  function automatic logic [NAME_W-1:0] tidy_name(logic [NAME_W-1:0] name);
    for (int b = 0; b < 8; b++) begin
      if (name[NAME_W-1-8*b -: 8] == 8'h00) return name & ~({NAME_W{1'b1}} >> (8 * b));
    end
    return name;
  endfunction

  function automatic void predict_contact(contact_cmd_t c);
    logic [NAME_W-1:0] key;
    contact_rsp_t      r;
    int                hit;
    key    = tidy_name({c.head, c.tail});
    r      = '0;
    r.last = 1'b1;
    hit    = -1;
    for (int j = 0; j < book_count; j++) begin
      if (hit < 0 && (c.op == OP_FIND_NAME || c.op == OP_DEL_NAME) && book_name[j] == key)
        hit = j;
      if (hit < 0 && (c.op == OP_FIND_PHONE || c.op == OP_DEL_PHONE) && book_phone[j] == c.phone)
        hit = j;
    end
    case (c.op)
      OP_ADD: begin
        if (book_count == TABLE_DEPTH) begin
          r.status = ST_FULL;
          full_hits++;
        end else begin
          book_phone[book_count] = c.phone;
          book_name[book_count]  = key;
          r.status               = ST_OK;
          r.index                = IDX_W'(book_count);
          r.phone                = c.phone;
          {r.head, r.tail}       = key;
          book_count++;
        end
        r.count = CNT_W'(book_count);
        due_rsp.push_back(r);
      end
      OP_FIND_NAME, OP_FIND_PHONE, OP_DEL_NAME, OP_DEL_PHONE: begin
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status         = ST_OK;
          r.index          = IDX_W'(hit);
          r.phone          = book_phone[hit];
          {r.head, r.tail} = book_name[hit];
          if (c.op == OP_DEL_NAME || c.op == OP_DEL_PHONE) begin
            for (int j = hit; j < book_count - 1; j++) begin
              book_phone[j] = book_phone[j + 1];
              book_name[j]  = book_name[j + 1];
            end
            book_count--;
          end
        end
        r.count = CNT_W'(book_count);
        due_rsp.push_back(r);
      end
      OP_LIST: begin
        if (book_count == 0) begin
          r.status = ST_EMPTY;
          due_rsp.push_back(r);
        end else begin
          for (int j = 0; j < book_count; j++) begin
            r.status         = ST_OK;
            r.index          = IDX_W'(j);
            r.phone          = book_phone[j];
            {r.head, r.tail} = book_name[j];
            r.count          = CNT_W'(book_count);
            r.last           = (j == book_count - 1);
            due_rsp.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic contact_rsp_t rsp_of(status_t st, int idx, logic [PHONE_W-1:0] ph,
                                          logic [HEAD_W-1:0] hd, logic [TAIL_W-1:0] tl,
                                          int cnt);
    contact_rsp_t r;
    r.status = st;
    r.index  = IDX_W'(idx);
    r.phone  = ph;
    r.head   = hd;
    r.tail   = tl;
    r.count  = CNT_W'(cnt);
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic plan_row_t mk_row(logic [OP_W-1:0] op, logic [PHONE_W-1:0] ph,
                                       logic [HEAD_W-1:0] hd, logic [TAIL_W-1:0] tl,
                                       int reps, bit typed, contact_rsp_t want);
    plan_row_t row;
    row.cmd   = '{op: op, phone: ph, head: hd, tail: tl};
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic logic [PHONE_W-1:0] rand_phone();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return PHONE_W'(w % 64'd100000000000);
  endfunction

  // Random name of 0 to 9 characters; bytes past the terminator are left as junk half the time.
  function automatic logic [NAME_W-1:0] rand_name();
    logic [NAME_W-1:0] n;
    int                len;
    len       = $urandom_range(9);
    n[71:40]  = $urandom;
    n[39:8]   = $urandom;
    n[7:0]    = 8'($urandom);
    for (int b = 0; b < len; b++) begin
      if (n[NAME_W-1-8*b -: 8] == 8'h00) n[NAME_W-1-8*b -: 8] = 8'h41;
    end
    if (len < 9) begin
      n[NAME_W-1-8*len -: 8] = 8'h00;
      if ($urandom_range(1) == 0) n = n & ~({NAME_W{1'b1}} >> (8 * (len + 1)));
    end
    return n;
  endfunction

  task automatic issue_cmd(input contact_cmd_t c);
    if ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req.valid        <= 1'b1;
    req.opcode       <= c.op;
    req.phone_number <= c.phone;
    req.name_head    <= c.head;
    req.name_tail    <= c.tail;
    do @(posedge clk); while (!req.ready);
    predict_contact(c);
    cmds_sent++;
  endtask

  task automatic log_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : rsp_check
    contact_rsp_t got;
    contact_rsp_t want;
    string        bad;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = status_t'(rsp.status);
      got.index  = rsp.entry_index;
      got.phone  = rsp.entry_phone;
      got.head   = rsp.entry_name_head;
      got.tail   = rsp.entry_name_tail;
      got.count  = rsp.entry_count;
      got.last   = rsp.last_result;
      beats_seen++;
      if (due_rsp.size() == 0) begin
        log_fault($sformatf("result beat with nothing outstanding: st=%0d idx=%0d",
                            got.status, got.index));
      end else begin
        want = due_rsp.pop_front();
        bad  = "";
        if (got.status !== want.status) bad = {bad, " status"};
        if (got.index !== want.index)   bad = {bad, " index"};
        if (got.phone !== want.phone)   bad = {bad, " phone"};
        if (got.head !== want.head)     bad = {bad, " name_head"};
        if (got.tail !== want.tail)     bad = {bad, " name_tail"};
        if (got.count !== want.count)   bad = {bad, " count"};
        if (got.last !== want.last)     bad = {bad, " last"};
        if (bad != "") begin
          log_fault($sformatf({"beat %0d wrong in%s\n  exp st=%0d idx=%0d ph=%0d hd=%h tl=%h",
                               " cnt=%0d last=%b\n  got st=%0d idx=%0d ph=%0d hd=%h tl=%h",
                               " cnt=%0d last=%b"},
                              beats_seen, bad,
                              want.status, want.index, want.phone, want.head, want.tail,
                              want.count, want.last,
                              got.status, got.index, got.phone, got.head, got.tail,
                              got.count, got.last));
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= idle_pct);
  end

  initial begin : stimulus
    plan_row_t         plan [$];
    contact_cmd_t      cmd;
    logic [NAME_W-1:0] name;
    logic [PHONE_W-1:0] pool_phone [4];
    logic [NAME_W-1:0] pool_name [4];
    opcode_t           op_menu [6];
    int                grow_cut [6];
    int                shrink_cut [6];
    bit                grow;
    int                roll;
    int                j;
    int                done_rand;

    op_menu          = '{OP_ADD, OP_FIND_NAME, OP_FIND_PHONE,
                         OP_DEL_NAME, OP_DEL_PHONE, OP_LIST};
    grow_cut         = '{55, 63, 71, 78, 85, 96};
    shrink_cut       = '{12, 22, 32, 58, 84, 96};
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.opcode       = '0;
    req.phone_number = '0;
    req.name_head    = '0;
    req.name_tail    = '0;
    book_count       = 0;
    fault_count      = 0;
    beats_seen       = 0;
    cmds_sent        = 0;
    full_hits        = 0;
    idle_pct         = 36;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty table: list, find and delete all report their error codes.
    plan.push_back(mk_row(OP_LIST, '0, '0, '0, 1, 1, rsp_of(ST_EMPTY, 0, '0, '0, '0, 0)));
    plan.push_back(mk_row(OP_FIND_NAME, '0, {"ALICE", 24'h0}, '0, 1, 1,
                          rsp_of(ST_NOT_FOUND, 0, '0, '0, '0, 0)));
    plan.push_back(mk_row(OP_DEL_PHONE, 37'd12345, '0, '0, 1, 1,
                          rsp_of(ST_NOT_FOUND, 0, '0, '0, '0, 0)));
    // Extremes of every field, an empty name, junk after the terminator, a full nine-byte name.
    plan.push_back(mk_row(OP_ADD, 37'd99999999999, '1, '1, 1, 1,
                          rsp_of(ST_OK, 0, 37'd99999999999, '1, '1, 1)));
    plan.push_back(mk_row(OP_ADD, '0, '0, 8'hA5, 1, 0, '0));
    plan.push_back(mk_row(OP_ADD, 37'd5550100, {"ALICE", 8'h00, 8'h7F, 8'h3A}, 8'h55, 1, 0, '0));
    plan.push_back(mk_row(OP_ADD, 37'h15_5555_5555, {"ALICE", 24'h0}, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_ADD, 37'h0A_AAAA_AAAA, "BARTHOLO", "M", 1, 0, '0));
    plan.push_back(mk_row(OP_FIND_NAME, '0, {"ALICE", 8'h00, "ZZ"}, 8'h11, 1, 0, '0));
    plan.push_back(mk_row(OP_FIND_PHONE, 37'h15_5555_5555, '0, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_FIND_NAME, '0, {8'h00, 56'hFF_0000_0000_0042}, 8'h42, 1, 0, '0));
    plan.push_back(mk_row(OP_SPARE, 37'd1, "NOBODY!!", "x", 1, 0, '0));
    plan.push_back(mk_row(OP_SPARE + 3'd1, '1, '1, '1, 1, 0, '0));
    plan.push_back(mk_row(OP_LIST, '0, '0, '0, 1, 0, '0));
    // With two entries of the same name, the first is taken and later ones move down.
    plan.push_back(mk_row(OP_DEL_NAME, '0, {"ALICE", 24'h0}, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_FIND_NAME, '0, {"ALICE", 24'h0}, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_DEL_PHONE, 37'd99999999999, '0, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_DEL_NAME, '0, {"NOBODY", 16'h0}, '0, 1, 1,
                          rsp_of(ST_NOT_FOUND, 0, '0, '0, '0, 3)));
    plan.push_back(mk_row(OP_FIND_PHONE, 37'd5550199, '0, '0, 1, 1,
                          rsp_of(ST_NOT_FOUND, 0, '0, '0, '0, 3)));
    plan.push_back(mk_row(OP_DEL_PHONE, 37'h0A_AAAA_AAAA, '0, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_LIST, '0, '0, '0, 1, 0, '0));
    // Fill the table, hit the full case, list it whole, then delete near the front.
    plan.push_back(mk_row(OP_ADD, 37'd2000000, {"FILLER", 8'h2D, 8'h01}, "x",
                          TABLE_DEPTH - 2, 0, '0));
    plan.push_back(mk_row(OP_ADD, 37'd7, "OVERFLOW", "!", 1, 1,
                          rsp_of(ST_FULL, 0, '0, '0, '0, int'(DEPTH_CNT))));
    plan.push_back(mk_row(OP_LIST, '0, '0, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_FIND_PHONE, 37'd2000000 + TABLE_DEPTH - 3, '0, '0, 1, 0, '0));
    plan.push_back(mk_row(OP_DEL_NAME, '0, {"FILLER", 8'h2D, 8'h01}, "x", 1, 0, '0));

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        cmd       = plan[i].cmd;
        cmd.phone = cmd.phone + PHONE_W'(k);
        cmd.head  = cmd.head + HEAD_W'(k);
        issue_cmd(cmd);
        if (plan[i].typed) begin
          void'(due_rsp.pop_back());
          due_rsp.push_back(plan[i].want);
        end
      end
    end

    // Random part: the table swings between filling and draining, and most keys
    // are taken from live entries or a small pool so that searches find something.
    for (int p = 0; p < 4; p++) begin
      pool_phone[p] = rand_phone();
      pool_name[p]  = rand_name();
    end
    grow      = (book_count < TABLE_DEPTH);
    done_rand = 0;
    while (done_rand < RAND_CMDS) begin
      idle_pct = (done_rand >= 50 && done_rand < 90) ? 0 : 36;
      roll     = $urandom_range(99);
      cmd.op   = OP_SPARE + OP_W'($urandom_range(1));
      for (int m = 5; m >= 0; m--) begin
        if (roll < (grow ? grow_cut[m] : shrink_cut[m])) cmd.op = op_menu[m];
      end
      cmd.phone = rand_phone();
      name      = rand_name();
      if (cmd.op != OP_ADD && book_count > 0 && $urandom_range(99) < 70) begin
        j         = $urandom_range(book_count - 1);
        cmd.phone = book_phone[j];
        name      = book_name[j];
      end else if ($urandom_range(99) < 40) begin
        j         = $urandom_range(3);
        cmd.phone = pool_phone[j];
        name      = pool_name[j];
      end
      {cmd.head, cmd.tail} = name;
      issue_cmd(cmd);
      if (cmd.op <= OP_LIST) done_rand++;
      if (grow && book_count == TABLE_DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      else if (!grow && book_count <= 1) grow = 1'b1;
    end

    req.valid <= 1'b0;
    idle_pct = 36;
    while (due_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands, checked %0d result beats, %0d adds to a full table.",
             cmds_sent, beats_seen, full_hits);
    $display("Faults found: %0d; predictions left over: %0d.", fault_count, due_rsp.size());
    if (fault_count == 0 && due_rsp.size() == 0) begin
      $display("contact_table_engine_top_test: done, clean");
    end else begin
      $display("contact_table_engine_top_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
